// ----- hw/rtl/sfr_pkg.sv -----
package sfr_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    // parser state codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SYNC1   = 3'd1;
    localparam logic [2:0] ST_LEN     = 3'd2;
    localparam logic [2:0] ST_ID      = 3'd3;
    localparam logic [2:0] ST_PAYLOAD = 3'd4;
    localparam logic [2:0] ST_CSUM    = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_BADSUM = 2'd2;
    localparam logic [1:0] KIND_BADLEN = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] id;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] length;
    } t_result;

endpackage

// ----- hw/rtl/serial_frame_receiver_top.sv -----
// A byte accepted into the input register passes its result (if any) on to the result register.
// Throughput: one byte per cycle while the result register has room; a byte that yields no result never waits.
// The input register and the result register let the link and the consumer
// stall independently; the parser advances whenever its result has room.
// Reset (i_rst_n low, synchronous): both registers empty, parser back to
// idle with length, id, sum and count cleared.
module serial_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte stream from the serial line
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    // parsed transactions
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_id,
    output logic [7:0] o_out_byte,
    output logic [7:0] o_out_index,
    output logic [7:0] o_out_length
);
    import sfr_pkg::*;

    // input register: one received byte waiting for the parser
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte, n_in_byte;

    // result register: one finished transaction waiting for the consumer
    t_result    r_out, n_out;

    t_result    w_res;
    logic       s_adv;

    // The parser consumes the held byte when it produces nothing, or when
    // the result register is empty or being drained this cycle.
    assign s_adv   = r_in_valid && (!w_res.valid || !r_out.valid || i_ready);
    assign o_ready = !r_in_valid || s_adv;

    sfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s_adv),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        if (i_valid && o_ready) begin
            n_in_valid = 1'b1;
            n_in_byte  = i_rx_byte;
        end else if (s_adv) begin
            n_in_valid = 1'b0;
        end

        n_out = r_out;
        if (s_adv && w_res.valid) begin
            n_out = w_res;
        end else if (i_ready) begin
            n_out.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        // payload registers, no reset needed
        r_in_byte    <= n_in_byte;
        r_out.kind   <= n_out.kind;
        r_out.id     <= n_out.id;
        r_out.data   <= n_out.data;
        r_out.index  <= n_out.index;
        r_out.length <= n_out.length;
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out.valid <= n_out.valid;
        end
    end

    assign o_valid      = r_out.valid;
    assign o_out_kind   = r_out.kind;
    assign o_out_id     = r_out.id;
    assign o_out_byte   = r_out.data;
    assign o_out_index  = r_out.index;
    assign o_out_length = r_out.length;

`ifndef SYNTHESIS
    a_in_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s_adv) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held byte lost while parser stalled");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_adv && w_res.valid) |=> r_out.valid)
        else $error("parser result dropped");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out.valid && !i_ready) |-> !(s_adv && w_res.valid))
        else $error("pending result overwritten");
`endif

endmodule

// ----- hw/rtl/sfr_parser.sv -----
module sfr_parser #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output sfr_pkg::t_result  o_res
);
    import sfr_pkg::*;

    // largest length whose payload still fits
    localparam logic [8:0] LEN_LIMIT = 9'(MAX_PAYLOAD + 2);

    logic [2:0] r_state, n_state;
    logic [7:0] r_length, n_length;
    logic [7:0] r_id, n_id;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_count, n_count;
    t_result    w_res;

    always_comb begin
        n_state  = r_state;
        n_length = r_length;
        n_id     = r_id;
        n_sum    = r_sum;
        n_count  = r_count;
        w_res    = '0;
        case (r_state)
            ST_SYNC1: begin
                n_state = (i_byte == SYNC_BYTE) ? ST_LEN : ST_IDLE;
            end
            ST_LEN: begin
                n_length = i_byte;
                n_sum    = i_byte;
                n_count  = 8'd0;
                if ({1'b0, i_byte} > LEN_LIMIT) begin
                    w_res.valid  = 1'b1;
                    w_res.kind   = KIND_BADLEN;
                    w_res.length = i_byte;
                    n_state      = ST_IDLE;
                end else begin
                    n_state = ST_ID;
                end
            end
            ST_ID: begin
                n_id    = i_byte;
                n_sum   = r_sum + i_byte;
                n_state = (r_length > 8'd2) ? ST_PAYLOAD : ST_CSUM;
            end
            ST_PAYLOAD: begin
                n_sum        = r_sum + i_byte;
                w_res.valid  = 1'b1;
                w_res.kind   = KIND_DATA;
                w_res.id     = r_id;
                w_res.data   = i_byte;
                w_res.index  = r_count;
                w_res.length = r_length;
                n_count      = r_count + 8'd1;
                if (({1'b0, n_count} + 9'd2) >= {1'b0, r_length}) begin
                    n_state = ST_CSUM;
                end
            end
            ST_CSUM: begin
                w_res.valid  = 1'b1;
                w_res.kind   = (i_byte == ~r_sum) ? KIND_OK : KIND_BADSUM;
                w_res.id     = r_id;
                w_res.data   = i_byte;
                w_res.length = r_length;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = (i_byte == SYNC_BYTE) ? ST_SYNC1 : ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_length <= 8'd0;
            r_id     <= 8'd0;
            r_sum    <= 8'd0;
            r_count  <= 8'd0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_length <= n_length;
            r_id     <= n_id;
            r_sum    <= n_sum;
            r_count  <= n_count;
        end
    end

    assign o_res = w_res;

`ifndef SYNTHESIS
    a_data_only_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && w_res.kind == KIND_DATA) |-> r_state == ST_PAYLOAD)
        else $error("data result outside payload");

    a_badlen_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_res.valid && w_res.kind == KIND_BADLEN) |=> r_state == ST_IDLE)
        else $error("parser not idle after length error");

    a_count_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAYLOAD) |-> ({1'b0, r_count} + 9'd2) < {1'b0, r_length})
        else $error("payload count past frame length");

    a_frame_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ID || r_state == ST_PAYLOAD) |-> {1'b0, r_length} <= LEN_LIMIT)
        else $error("oversize frame accepted");
`endif

endmodule
